/* design/pwti_pkg.sv */
// pwti_pkg: shared types and constants for the pitch to wing tilt interpolator
// holds field widths, opcodes, controller states and the command/status structs
// no dependencies
`timescale 1ns / 1ps

package pwti_pkg;

    localparam int DEF_TABLE_POINTS = 13;

    localparam int IDX_W  = 4;              // point_index port width
    localparam int X_W    = 14;             // breakpoint x, magnitude, limit
    localparam int Y_W    = 15;             // breakpoint y, pitch, wing angle
    localparam int ENT_W  = X_W + Y_W;      // one table entry {x, y}
    localparam int DY_W   = Y_W + 1;        // difference of two y values
    localparam int PROD_W = Y_W + X_W;      // |dy| * (mag - x0)
    localparam int QUO_W  = 16;             // quotient bits resolved by the divider
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS = QUO_W / DIV_BITS_PER_STEP;
    localparam int CNT_W  = $clog2(DIV_STEPS);

    localparam logic [X_W-1:0] LIMIT_RESET = X_W'(4500);
    localparam int OUT_MAX = (1 << (Y_W - 1)) - 1;
    localparam int OUT_MIN = -(1 << (Y_W - 1));

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_FETCH_A,
        S_FETCH_B,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_MID,
        RD_LOW,
        RD_HIGH
    } t_rd_sel;

    typedef struct packed {
        logic    write_pt;
        logic    load_query;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    search_upd;
        logic    latch_a;
        logic    latch_prod;
        logic    div_step;
        logic    fin;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic search_done;
        logic edge_pt;
        logic out_free;
    } t_sts;

endpackage

/* design/pwti_ctrl.sv */
// pwti_ctrl: sequencer for one query at a time (search, fetch, multiply, divide, output)
// depends on pwti_pkg
`timescale 1ns / 1ps

module pwti_ctrl
    import pwti_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_opcode,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_opcode == OP_QUERY)) begin
                    n_state = S_SEARCH_RD;
                end
            end
            S_SEARCH_RD: begin
                n_state = i_sts.search_done ? S_FETCH_A : S_SEARCH_CMP;
            end
            S_SEARCH_CMP: n_state = S_SEARCH_RD;
            S_FETCH_A:    n_state = S_FETCH_B;
            S_FETCH_B:    n_state = S_MUL;
            S_MUL: begin
                n_state = i_sts.edge_pt ? S_FIN : S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_MID;
        case (r_state)
            S_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.write_pt   = w_accept && (i_opcode == OP_WRITE);
                o_cmd.load_query = w_accept && (i_opcode == OP_QUERY);
            end
            S_SEARCH_RD: begin
                o_cmd.rd_en  = !i_sts.search_done;
                o_cmd.rd_sel = RD_MID;
            end
            S_SEARCH_CMP: o_cmd.search_upd = 1'b1;
            S_FETCH_A: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LOW;
            end
            S_FETCH_B: begin
                o_cmd.latch_a = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_HIGH;
            end
            S_MUL:  o_cmd.latch_prod = 1'b1;
            S_DIV:  o_cmd.div_step   = 1'b1;
            S_FIN:  o_cmd.fin        = 1'b1;
            S_OUT:  o_cmd.out_load   = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* design/pwti_dp.sv */
// pwti_dp: breakpoint memory, search registers, multiplier, radix-4 divider, output register
// depends on pwti_pkg, driven by pwti_ctrl commands
`timescale 1ns / 1ps

module pwti_dp
    import pwti_pkg::*;
#(
    parameter int TABLE_POINTS = DEF_TABLE_POINTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [X_W-1:0]        i_cfg_data,
    input  logic [IDX_W-1:0]      i_point_index,
    input  logic [X_W-1:0]        i_point_x,
    input  logic signed [Y_W-1:0] i_point_y,
    input  logic signed [Y_W-1:0] i_pitch_cd,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic signed [Y_W-1:0] o_wing_angle
);

    localparam int AW = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
    localparam int LW = $clog2(TABLE_POINTS + 1);

    logic [ENT_W-1:0] r_mem [TABLE_POINTS];
    logic [ENT_W-1:0] r_rd_data;
    logic [X_W-1:0]   r_limit;
    logic [X_W-1:0]   r_mag;
    logic             r_neg;
    logic [LW-1:0]    r_lo, r_hp1;
    logic [X_W-1:0]   r_x0;
    logic signed [Y_W-1:0] r_y0;
    logic signed [Y_W-1:0] r_base;
    logic             r_edge;
    logic [X_W-1:0]   r_den;
    logic [X_W-1:0]   r_rem;
    logic [QUO_W-1:0] r_dvd;
    logic             r_qneg;
    logic signed [Y_W-1:0] r_final;
    logic             r_out_valid;
    logic signed [Y_W-1:0] r_out_data;

    logic [X_W-1:0]        w_rd_x;
    logic signed [Y_W-1:0] w_rd_y;
    logic [LW-1:0]         w_mid;
    logic [AW-1:0]         w_rd_addr;
    logic                  w_lo_zero, w_lo_top;

    assign w_rd_x = r_rd_data[ENT_W-1:Y_W];
    assign w_rd_y = $signed(r_rd_data[Y_W-1:0]);

    assign w_mid     = r_lo + ((r_hp1 - r_lo - LW'(1)) >> 1);
    assign w_lo_zero = (r_lo == '0);
    assign w_lo_top  = (r_lo == LW'(TABLE_POINTS));

    always_comb begin
        case (i_cmd.rd_sel)
            RD_MID:  w_rd_addr = w_mid[AW-1:0];
            RD_LOW:  w_rd_addr = w_lo_zero ? '0 : AW'(r_lo - LW'(1));
            RD_HIGH: w_rd_addr = w_lo_top ? AW'(TABLE_POINTS - 1) : AW'(r_lo);
            default: w_rd_addr = '0;
        endcase
    end

    // breakpoint table, slots beyond the table are dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_pt && (int'(i_point_index) < TABLE_POINTS)) begin
            r_mem[AW'(i_point_index)] <= {i_point_x, i_point_y};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // clamp and magnitude of the query pitch
    logic signed [Y_W:0] w_pitch, w_lim_pos, w_lim_neg, w_clamped, w_abs;

    always_comb begin
        w_pitch   = {i_pitch_cd[Y_W-1], i_pitch_cd};
        w_lim_pos = $signed({2'b00, r_limit});
        w_lim_neg = -w_lim_pos;
        if (w_pitch > w_lim_pos) begin
            w_clamped = w_lim_pos;
        end else if (w_pitch < w_lim_neg) begin
            w_clamped = w_lim_neg;
        end else begin
            w_clamped = w_pitch;
        end
        w_abs = w_clamped[Y_W] ? -w_clamped : w_clamped;
    end

    // interpolation operands
    logic signed [DY_W-1:0] w_dy, w_dy_abs;
    logic [X_W-1:0]         w_dm;
    logic [PROD_W-1:0]      w_prod;

    always_comb begin
        w_dy     = DY_W'(w_rd_y) - DY_W'(r_y0);
        w_dy_abs = w_dy[DY_W-1] ? -w_dy : w_dy;
        w_dm     = r_mag - r_x0;
        w_prod   = PROD_W'(w_dy_abs[Y_W-1:0]) * PROD_W'(w_dm);
    end

    // two restoring division steps per cycle
    logic [X_W:0]     w_trial;
    logic [X_W-1:0]   w_rem_nx;
    logic [QUO_W-1:0] w_dvd_nx;

    always_comb begin
        w_rem_nx = r_rem;
        w_dvd_nx = r_dvd;
        w_trial  = '0;
        for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
            w_trial  = {w_rem_nx, w_dvd_nx[QUO_W-1]};
            w_dvd_nx = {w_dvd_nx[QUO_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                w_rem_nx    = X_W'(w_trial - {1'b0, r_den});
                w_dvd_nx[0] = 1'b1;
            end else begin
                w_rem_nx = w_trial[X_W-1:0];
            end
        end
    end

    // final sign handling and saturation
    logic signed [QUO_W:0]   w_q;
    logic signed [QUO_W+1:0] w_sum;
    logic signed [QUO_W+2:0] w_res;
    logic signed [Y_W-1:0]   w_sat;

    always_comb begin
        w_q   = r_edge ? '0 : (r_qneg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd}));
        w_sum = (QUO_W+2)'(r_base) + (QUO_W+2)'(w_q);
        w_res = r_neg ? -(QUO_W+3)'(w_sum) : (QUO_W+3)'(w_sum);
        if (w_res > (QUO_W+3)'(OUT_MAX)) begin
            w_sat = Y_W'(OUT_MAX);
        end else if (w_res < (QUO_W+3)'(OUT_MIN)) begin
            w_sat = Y_W'(OUT_MIN);
        end else begin
            w_sat = w_res[Y_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_mag <= w_abs[X_W-1:0];
            r_neg <= w_clamped[Y_W];
            r_lo  <= '0;
            r_hp1 <= LW'(TABLE_POINTS);
        end
        if (i_cmd.search_upd) begin
            if (w_rd_x < r_mag) begin
                r_lo <= w_mid + LW'(1);
            end else begin
                r_hp1 <= w_mid;
            end
        end
        if (i_cmd.latch_a) begin
            r_x0 <= w_rd_x;
            r_y0 <= w_rd_y;
        end
        if (i_cmd.latch_prod) begin
            r_edge <= w_lo_zero || w_lo_top;
            r_base <= w_lo_top ? w_rd_y : r_y0;
            r_den  <= w_rd_x - r_x0;
            r_rem  <= X_W'(w_prod[PROD_W-1:QUO_W]);
            r_dvd  <= w_prod[QUO_W-1:0];
            r_qneg <= w_dy[DY_W-1];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_rem_nx;
            r_dvd <= w_dvd_nx;
        end
        if (i_cmd.fin) begin
            r_final <= w_sat;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_final;
        end
    end

    assign o_sts.search_done = (r_lo == r_hp1);
    assign o_sts.edge_pt     = w_lo_zero || w_lo_top;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_wing_angle = r_out_data;

endmodule

/* design/pitch_to_wing_tilt_interpolator.sv */
// pitch_to_wing_tilt_interpolator: top level, joins the sequencer and the datapath
// depends on pwti_pkg, pwti_ctrl, pwti_dp
`timescale 1ns / 1ps

// usage
//   input channel (i_valid / o_ready) carries one item: opcode 0 writes breakpoint
//   i_point_index with (i_point_x, i_point_y), opcode 1 queries i_pitch_cd
//   output channel (o_valid / i_ready) returns one wing angle per query item,
//   nothing for a write item
//   i_cfg_we / i_cfg_data load the pitch limit, only while the block is idle
// timing
//   a write item is stored in the cycle it is taken, the next item can follow at once
//   a query runs through the search, the fetch of the two bracketing points, the multiply,
//   the divide and the sign and saturation step before o_valid; the divide is skipped when the pitch is at
//   or below the first x or above the last x;
//   each search step reads the single-port table memory and then compares, and the
//   divider resolves two quotient bits per cycle
//   only one query is in flight, o_ready is high while the sequencer is idle
// reset
//   synchronous, active low: sequencer idle, output empty, limit back to 45.00 deg;
//   table contents are not cleared and must be written before any query
// stall
//   the result waits in the output register, a finished query holds there and
//   the sequencer is idle again, so the next item is taken meanwhile; a second
//   query waits at its last step until the output register frees

module pitch_to_wing_tilt_interpolator
    import pwti_pkg::*;
#(
    parameter int TABLE_POINTS = DEF_TABLE_POINTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [IDX_W-1:0]      i_point_index,
    input  logic [X_W-1:0]        i_point_x,
    input  logic signed [Y_W-1:0] i_point_y,
    input  logic signed [Y_W-1:0] i_pitch_cd,
    // result item channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [Y_W-1:0] o_wing_angle,
    // pitch limit register
    input  logic                  i_cfg_we,
    input  logic [X_W-1:0]        i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: search loop, fetch of the bracketing points, divide count
    pwti_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_sts    (w_sts),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    // datapath: table memory, clamp, multiply, divide, negate and saturate
    pwti_dp #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_pitch_cd    (i_pitch_cd),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_wing_angle  (o_wing_angle)
    );

endmodule

/* test/pitch_to_wing_tilt_interpolator_tb.sv */
// pitch_to_wing_tilt_interpolator_tb: self-checking bench for the pitch to wing tilt interpolator
// loads breakpoint tables, sends pitch queries and compares every wing angle with its own predictor
// depends on pwti_pkg and pitch_to_wing_tilt_interpolator
`timescale 1ns / 1ps

module pitch_to_wing_tilt_interpolator_tb;
    import pwti_pkg::*;

    localparam int N_POINTS         = DEF_TABLE_POINTS;
    localparam int HALF_PERIOD      = 6;
    localparam int SETTLE_CYCLES    = 40;     // well past the longest query latency
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int NUM_PHASES       = 8;
    localparam int PHASE_ITEMS      = 230;
    localparam int MAX_WAIT         = 10;

    // one input item as it sits in the send queue
    typedef struct packed {
        t_op                  op;
        logic [IDX_W-1:0]     idx;
        logic [X_W-1:0]       x;
        logic signed [Y_W-1:0] y;
        logic signed [Y_W-1:0] pitch;
    } t_tilt_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_opcode = 1'b0;
    logic [IDX_W-1:0]      i_point_index = '0;
    logic [X_W-1:0]        i_point_x = '0;
    logic signed [Y_W-1:0] i_point_y = '0;
    logic signed [Y_W-1:0] i_pitch_cd = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic signed [Y_W-1:0] o_wing_angle;
    logic                  i_cfg_we = 1'b0;
    logic [X_W-1:0]        i_cfg_data = '0;

    // bench copy of the block state, updated as items are accepted
    int tilt_x [N_POINTS];
    int tilt_y [N_POINTS];
    int limit_model = int'(LIMIT_RESET);

    // breakpoint x values as queued, used only to aim queries at them
    int plan_x [N_POINTS];

    t_tilt_item            pending_items [$];
    logic signed [Y_W-1:0] expected_angles [$];

    int error_count   = 0;
    int send_gap_max  = MAX_WAIT;
    int recv_gap_max  = MAX_WAIT;
    int hold_requests = 0;
    int holds_started = 0;
    int send_wait     = 0;
    int recv_wait     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    pitch_to_wing_tilt_interpolator #(
        .TABLE_POINTS(N_POINTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_pitch_cd    (i_pitch_cd),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_wing_angle  (o_wing_angle),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // clamp, take the magnitude, binary search, interpolate, restore the sign, saturate
    function automatic logic signed [Y_W-1:0] tilt_for_pitch(logic signed [Y_W-1:0] pitch);
        int     p;
        int     mag;
        int     lo;
        int     hi;
        int     mid;
        int     res;
        longint num;
        longint den;
        p = pitch;
        if (p > limit_model) p = limit_model;
        if (p < -limit_model) p = -limit_model;
        mag = (p < 0) ? -p : p;
        lo = 0;
        hi = N_POINTS - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (tilt_x[mid] < mag) lo = mid + 1;
            else hi = mid - 1;
        end
        if (lo <= 0) begin
            res = tilt_y[0];
        end else if (lo >= N_POINTS) begin
            res = tilt_y[N_POINTS-1];
        end else begin
            // in an increasing table the search leaves x[lo-1] < mag <= x[lo], so the span is positive
            num = longint'(tilt_y[lo] - tilt_y[lo-1]) * longint'(mag - tilt_x[lo-1]);
            den = longint'(tilt_x[lo] - tilt_x[lo-1]);
            if (den <= 0) res = tilt_y[lo];
            else res = tilt_y[lo-1] + int'(num / den);   // sv division truncates toward zero
        end
        if (p < 0) res = -res;
        // negating the most negative angle saturates
        if (res > OUT_MAX) res = OUT_MAX;
        if (res < OUT_MIN) res = OUT_MIN;
        return Y_W'(res);
    endfunction

    function automatic t_tilt_item point_item(int idx, int x, int y);
        t_tilt_item it;
        it.op    = OP_WRITE;
        it.idx   = IDX_W'(idx);
        it.x     = X_W'(x);
        it.y     = Y_W'(y);
        it.pitch = Y_W'($urandom);
        if (idx < N_POINTS) plan_x[idx] = x;
        return it;
    endfunction

    function automatic t_tilt_item pitch_item(int p);
        t_tilt_item it;
        it.op    = OP_QUERY;
        it.idx   = IDX_W'($urandom);
        it.x     = X_W'($urandom);
        it.y     = Y_W'($urandom);
        it.pitch = Y_W'(p);
        return it;
    endfunction

    // mostly in the stated range, now and then anywhere in 15 bits
    function automatic int random_angle();
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 32767)) - 16384;
        return int'($urandom_range(0, 18000)) - 9000;
    endfunction

    // mostly queries aimed at breakpoints, the limit and the whole range,
    // with stray breakpoint writes that can leave the table out of order
    function automatic t_tilt_item random_item(int lim);
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 9) begin
            v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 9000);
            return point_item($urandom_range(0, N_POINTS - 1), v, random_angle());
        end
        if (roll < 12) return point_item($urandom_range(N_POINTS, 15), $urandom_range(0, 16383),
                                         random_angle());
        if (roll < 60) v = int'($urandom_range(0, 18000)) - 9000;
        else if (roll < 80) v = plan_x[$urandom_range(0, N_POINTS - 1)] + int'($urandom_range(0, 2)) - 1;
        else if (roll < 92) v = lim + int'($urandom_range(0, 4)) - 2;
        else v = int'($urandom_range(0, 32767)) - 16384;
        if (roll >= 60 && roll < 92 && $urandom_range(0, 1) == 1) v = -v;
        return pitch_item(v);
    endfunction

    // a full, strictly increasing table with random content
    task automatic queue_table();
        int x;
        x = $urandom_range(0, 600);
        for (int i = 0; i < N_POINTS; i++) begin
            if (i > 0) x += $urandom_range(1, 700);
            pending_items.push_back(point_item(i, x, random_angle()));
        end
    endtask

    // the sender pauses here until every query has been answered
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_angles.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // limit register write, only called with the block idle
    task automatic write_limit(int v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_data  <= X_W'(v);
        limit_model = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // driver: takes items from the send queue, random wait before each one
    always @(posedge i_clk) begin
        t_tilt_item it;
        logic       stuck;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            send_wait = 0;
        end else begin
            stuck = i_valid && !o_ready;
            if (i_valid && o_ready) begin
                // item taken at this edge: update the table copy or predict the answer
                if (i_opcode == OP_WRITE) begin
                    if (int'(i_point_index) < N_POINTS) begin
                        tilt_x[i_point_index] = int'(i_point_x);
                        tilt_y[i_point_index] = int'(i_point_y);
                    end
                end else begin
                    expected_angles.push_back(tilt_for_pitch(i_pitch_cd));
                end
                send_wait = $urandom_range(0, send_gap_max);
            end
            if (!stuck) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    it = pending_items.pop_front();
                    i_opcode      <= it.op;
                    i_point_index <= it.idx;
                    i_point_x     <= it.x;
                    i_point_y     <= it.y;
                    i_pitch_cd    <= it.pitch;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each wing angle, random stalls plus the long hold-off
    always @(posedge i_clk) begin
        logic signed [Y_W-1:0] want;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_angles.size() == 0) begin
                    $display("%0t ns: wing_angle expected none, actual %0d", $time, o_wing_angle);
                    error_count++;
                end else begin
                    want = expected_angles.pop_front();
                    if (o_wing_angle !== want) begin
                        $display("%0t ns: wing_angle expected %0d, actual %0d",
                                 $time, want, o_wing_angle);
                        error_count++;
                    end
                end
                recv_wait = $urandom_range(0, recv_gap_max);
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            if (holds_started != hold_requests) begin
                holds_started = hold_requests;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) hold_left--;
            i_ready <= (recv_wait == 0 && hold_left == 0);
        end
    end

    // watchdog: ends the run when no item moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: timeout, no item moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL pitch_to_wing_tilt_interpolator");
            $finish;
        end
    end

    initial begin
        int lim;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table at the reset limit: x from 300 to 4140, y hits both
        // extremes and the last point holds the most negative angle
        pending_items.push_back(point_item(0, 300, -2000));
        pending_items.push_back(point_item(1, 620, -9000));
        pending_items.push_back(point_item(2, 940, 0));
        pending_items.push_back(point_item(3, 1260, 1500));
        pending_items.push_back(point_item(4, 1580, 9000));
        pending_items.push_back(point_item(5, 1900, 4000));
        pending_items.push_back(point_item(6, 2220, 100));
        pending_items.push_back(point_item(7, 2540, -100));
        pending_items.push_back(point_item(8, 2860, 2500));
        pending_items.push_back(point_item(9, 3180, 3333));
        pending_items.push_back(point_item(10, 3500, -7777));
        pending_items.push_back(point_item(11, 3820, 5));
        pending_items.push_back(point_item(12, 4140, -16384));
        // slots past the table are dropped
        pending_items.push_back(point_item(N_POINTS, 0, -16384));
        pending_items.push_back(point_item(15, 16383, 16383));
        // below the table, on the first x, interior with truncation, tiny negative
        pending_items.push_back(pitch_item(0));
        pending_items.push_back(pitch_item(300));
        pending_items.push_back(pitch_item(461));
        pending_items.push_back(pitch_item(-461));
        pending_items.push_back(pitch_item(-1));
        // on the last x, above the table, clamped both ways, negation saturating
        pending_items.push_back(pitch_item(4140));
        pending_items.push_back(pitch_item(4400));
        pending_items.push_back(pitch_item(9000));
        pending_items.push_back(pitch_item(-9000));
        pending_items.push_back(pitch_item(-16384));
        // table no longer increasing, search answer stands as found
        pending_items.push_back(point_item(5, 5000, 4000));
        pending_items.push_back(pitch_item(2000));
        wait_drained();

        // random phases, each under its own limit, extremes included
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0, 3, 7: lim = 9000;
                1:       lim = 0;
                5:       lim = 1;
                default: lim = $urandom_range(1, 8999);
            endcase
            write_limit(lim);
            // two phases run back to back with no idling on either side
            send_gap_max = (ph == 2 || ph == 6) ? 0 : MAX_WAIT;
            recv_gap_max = send_gap_max;
            queue_table();
            for (int n = N_POINTS; n < PHASE_ITEMS; n++)
                pending_items.push_back(random_item(lim));
            // receiver holds off while the sender keeps offering, block backs up
            if (ph == 3) hold_requests++;
            wait_drained();
        end

        if (error_count == 0) begin
            $display("PASS pitch_to_wing_tilt_interpolator");
        end else begin
            $display("FAIL pitch_to_wing_tilt_interpolator");
        end
        $finish;
    end

endmodule

/* pitch_to_wing_tilt_interpolator.f */
design/pwti_pkg.sv
design/pwti_ctrl.sv
design/pwti_dp.sv
design/pitch_to_wing_tilt_interpolator.sv
test/pitch_to_wing_tilt_interpolator_tb.sv
